@@ src/wmbfc_pkg.sv @@
// wmbfc_pkg: types, layout constants and the crc-16 byte update for the
// wireless m-bus block crc checker. No dependencies.
`timescale 1ns / 1ps

package wmbfc_pkg;

	localparam int unsigned LEN_W       = 9;
	localparam int unsigned POS_W       = 9;
	localparam logic [8:0]  MAX_FRAME   = 9'd256;
	localparam logic [15:0] CRC_POLY    = 16'h3D65;
	localparam logic [8:0]  MIN_LEN     = 9'd12;
	localparam logic [8:0]  B_SPLIT_LEN = 9'd128;
	localparam logic [7:0]  B_FIRST_DATA = 8'd126;
	localparam logic [7:0]  A_FIRST_DATA = 8'd10;
	localparam logic [7:0]  A_BLOCK_DATA = 8'd16;
	localparam logic [9:0]  A_BLOCK_TOTAL = 10'd18;

	typedef struct packed {
		logic             frame_start;
		logic             format_b;
		logic [LEN_W-1:0] frame_size;
		logic [7:0]       data_byte;
	} item_t;

	typedef struct packed {
		logic crc_ok;
		logic too_short;
	} result_t;

	typedef enum logic [3:0] {
		PH_DATA   = 4'b0001,
		PH_CRC_HI = 4'b0010,
		PH_CRC_LO = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	// msb-first crc-16 over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			if (c[15] ^ b[i]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ src/wmbfc_core.sv @@
// wmbfc_core: frame tracking state and the per-beat block/crc update.
// Uses wmbfc_pkg.
`timescale 1ns / 1ps

module wmbfc_core
	import wmbfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	output logic    emit,
	output result_t res
);

	logic [15:0]      crc_q, held_q;
	logic [POS_W-1:0] pos_q;
	phase_t           phase_q;
	logic [7:0]       left_q;
	logic             fail_q;

	logic [LEN_W-1:0] len_c;
	logic             restart;
	logic [7:0]       n_first;
	logic [15:0]      crc_e, held_e;
	logic [POS_W-1:0] pos_e;
	phase_t           phase_e;
	logic [7:0]       left_e;
	logic             fail_e;
	logic [9:0]       len10, pos_n, rem;
	logic             nb_check;
	logic [7:0]       nb_left;
	logic [7:0]       left_dec;
	logic [15:0]      crc_n, held_n;
	phase_t           phase_n;
	logic [7:0]       left_n;
	logic             fail_n;
	logic [POS_W-1:0] pos_next;

	always_comb begin
		if (item.frame_size == '0) begin
			len_c = 9'd1;
		end else if (item.frame_size > MAX_FRAME) begin
			len_c = MAX_FRAME;
		end else begin
			len_c = item.frame_size;
		end
	end

	assign restart = item.frame_start || (pos_q == '0);

	always_comb begin
		if (!item.format_b) begin
			n_first = A_FIRST_DATA;
		end else if (len_c > B_SPLIT_LEN) begin
			n_first = B_FIRST_DATA;
		end else if (len_c >= 9'd2) begin
			n_first = 8'(len_c - 9'd2);
		end else begin
			n_first = 8'd0;
		end
	end

	always_comb begin
		if (restart) begin
			crc_e   = '0;
			held_e  = '0;
			fail_e  = 1'b0;
			pos_e   = '0;
			left_e  = n_first;
			phase_e = (n_first == 8'd0) ? PH_CRC_HI : PH_DATA;
		end else begin
			crc_e   = crc_q;
			held_e  = held_q;
			fail_e  = fail_q;
			pos_e   = pos_q;
			left_e  = left_q;
			phase_e = phase_q;
		end
	end

	assign len10 = {1'b0, len_c};
	assign pos_n = {1'b0, pos_e} + 10'd1;
	assign rem   = (len10 > pos_n) ? (len10 - pos_n) : 10'd0;

	// layout of the block that starts right after a crc
	always_comb begin
		nb_check = 1'b0;
		nb_left  = 8'd0;
		if (!item.format_b) begin
			if (rem >= A_BLOCK_TOTAL) begin
				nb_check = 1'b1;
				nb_left  = A_BLOCK_DATA;
			end else if (rem >= 10'd3) begin
				nb_check = 1'b1;
				nb_left  = 8'(rem - 10'd2);
			end
		end else if (len_c > B_SPLIT_LEN && pos_n == {1'b0, B_SPLIT_LEN} && rem >= 10'd2) begin
			nb_check = 1'b1;
			nb_left  = 8'(rem - 10'd2);
		end
	end

	assign left_dec = left_e - 8'd1;

	always_comb begin
		crc_n   = crc_e;
		held_n  = held_e;
		fail_n  = fail_e;
		left_n  = left_e;
		phase_n = phase_e;
		case (phase_e)
			PH_DATA: begin
				crc_n  = crc_byte(crc_e, item.data_byte);
				left_n = left_dec;
				if (left_dec == 8'd0) begin
					phase_n = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				held_n  = {item.data_byte, 8'h00};
				phase_n = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				if ((held_e | {8'h00, item.data_byte}) != ~crc_e) begin
					fail_n = 1'b1;
				end
				crc_n = '0;
				if (nb_check) begin
					left_n  = nb_left;
					phase_n = (nb_left == 8'd0) ? PH_CRC_HI : PH_DATA;
				end else begin
					left_n  = 8'd0;
					phase_n = PH_SKIP;
				end
			end
			default: begin
			end
		endcase
		emit = (pos_n == len10);
		if (emit) begin
			left_n  = 8'd0;
			phase_n = PH_SKIP;
		end
	end

	assign res.too_short = (len_c < MIN_LEN);
	assign res.crc_ok    = !res.too_short && !fail_n;
	assign pos_next      = (pos_e == '1) ? pos_e : pos_n[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= '0;
			held_q  <= '0;
			pos_q   <= '0;
			phase_q <= PH_DATA;
			left_q  <= '0;
			fail_q  <= 1'b0;
		end else if (step_en) begin
			crc_q   <= crc_n;
			held_q  <= held_n;
			pos_q   <= pos_next;
			phase_q <= phase_n;
			left_q  <= left_n;
			fail_q  <= fail_n;
		end
	end

endmodule

@@ src/wmbus_frame_block_crc_check.sv @@
// wmbus_frame_block_crc_check: top level, input register, output register.
// Uses wmbfc_pkg and wmbfc_core.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------
//   input    | item_valid   | item_stall   | item   (item_t)
//   output   | result_valid | result_stall | result (result_t)
//
// One byte per cycle sustained while item_stall is low; a verdict's last byte passes
// the input register, then the result register, which presents the verdict.
// The crc-16 byte update and block bookkeeping sit between those registers.
// Reset clears all frame state; the first byte after reset starts a frame.
// A held result stalls the input only when the waiting byte also ends a frame.

`timescale 1ns / 1ps

module wmbus_frame_block_crc_check
	import wmbfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	item_t   item_s1;
	logic    valid_s1;
	logic    emit;
	result_t res_c;
	logic    adv;
	logic    step_en;
	result_t result_q;
	logic    result_valid_q;

	wmbfc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.emit    (emit),
		.res     (res_c)
	);

	// the stage moves unless it has a verdict and the result slot is blocked
	assign adv        = !emit || !result_valid_q || !result_stall;
	assign step_en    = valid_s1 && adv;
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_en && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			result_q <= res_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ test/wmbus_frame_block_crc_check_tb.sv @@
// wmbus_frame_block_crc_check_tb: self-checking bench for the m-bus block crc checker,
// a directed table then random frames with valid and corrupted crcs, scored per verdict.
// Depends on wmbfc_pkg and wmbus_frame_block_crc_check.
`timescale 1ns / 1ps

module wmbus_frame_block_crc_check_tb;
	import wmbfc_pkg::*;

	localparam int POS_SAT        = 511;
	localparam int LEN_FIELD_MAX  = 511;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BEATS    = 160;
	localparam int PHASE_VERDICTS = 4;
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct {
		item_t   it;
		bit      known;
		result_t verdict;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// predictor state
	logic [15:0] run_crc = '0;
	logic [8:0]  frame_pos = '0;
	logic [15:0] held_hi = '0;
	phase_t      blk_phase = PH_DATA;
	logic [7:0]  blk_left = '0;
	logic        frame_bad = 1'b0;

	result_t     verdict_q[$];
	stim_row_t   dir_rows[$];
	result_t     want_v;
	int          errors = 0;
	int          cycles = 0;
	int          beats_sent = 0;
	int          verdicts_due = 0;
	int          send_idle = 0;
	int          recv_stall = 0;

	wmbus_frame_block_crc_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int k = 0; k < 8; k++) begin
			fb = r[15] ^ b[7-k];
			r = r << 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic open_block(input int pos, input int len, input bit fmt_b, input bit first);
		int n;
		int rem;
		bit chk;
		n = 0;
		chk = 1'b1;
		rem = (len > pos) ? len - pos : 0;
		if (first) begin
			if (!fmt_b) begin
				n = int'(A_FIRST_DATA);
			end else if (len > B_SPLIT_LEN) begin
				n = int'(B_FIRST_DATA);
			end else begin
				n = (len >= 2) ? len - 2 : 0;
			end
		end else if (!fmt_b) begin
			if (rem >= A_BLOCK_TOTAL) begin
				n = int'(A_BLOCK_DATA);
			end else if (rem >= 3) begin
				n = rem - 2;
			end else begin
				chk = 1'b0;
			end
		end else if (len > B_SPLIT_LEN && pos == B_SPLIT_LEN && rem >= 2) begin
			n = rem - 2;
		end else begin
			chk = 1'b0;
		end
		if (!chk) begin
			blk_phase = PH_SKIP;
			blk_left = '0;
		end else begin
			blk_left = n[7:0];
			// empty block goes straight to its crc bytes
			blk_phase = (blk_left == 0) ? PH_CRC_HI : PH_DATA;
		end
	endtask

	task automatic predict_verdict(input item_t it, output bit has, output result_t v);
		int len;
		int pos;
		has = 1'b0;
		v = '0;
		len = int'(it.frame_size);
		if (len == 0) begin
			len = 1;
		end
		if (len > MAX_FRAME) begin
			len = int'(MAX_FRAME);
		end
		if (it.frame_start || frame_pos == 0) begin
			run_crc = '0;
			held_hi = '0;
			frame_bad = 1'b0;
			frame_pos = '0;
			open_block(0, len, it.format_b, 1'b1);
		end
		pos = int'(frame_pos);
		case (blk_phase)
			PH_DATA: begin
				run_crc = crc16_step(run_crc, it.data_byte);
				blk_left = blk_left - 8'd1;
				if (blk_left == 0) begin
					blk_phase = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				held_hi = {it.data_byte, 8'h00};
				blk_phase = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				if ((held_hi | {8'h00, it.data_byte}) != ~run_crc) begin
					frame_bad = 1'b1;
				end
				run_crc = '0;
				open_block(pos + 1, len, it.format_b, 1'b0);
			end
			default: ;
		endcase
		if (pos + 1 == len) begin
			has = 1'b1;
			v.too_short = (len < MIN_LEN);
			v.crc_ok = !v.too_short && !frame_bad;
			blk_phase = PH_SKIP;
			blk_left = '0;
		end
		frame_pos = (pos < POS_SAT) ? 9'(pos + 1) : 9'(POS_SAT);
	endtask

	task automatic add_row(input bit s, input bit fb, input int len, input logic [7:0] b,
			input bit known, input bit ok, input bit sh);
		stim_row_t r;
		r.it.frame_start = s;
		r.it.format_b = fb;
		r.it.frame_size = 9'(len);
		r.it.data_byte = b;
		r.known = known;
		r.verdict.crc_ok = ok;
		r.verdict.too_short = sh;
		dir_rows.push_back(r);
	endtask

	// present one beat, wait for it to be taken, then queue its expected verdict
	task automatic push_beat(input item_t it, input bit known, input result_t typed);
		bit      has;
		result_t v;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predict_verdict(it, has, v);
		if (known) begin
			verdict_q.push_back(typed);
		end else if (has) begin
			verdict_q.push_back(v);
		end
		if (has) begin
			verdicts_due++;
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_frame();
		int    pick;
		int    len_field;
		int    len_true;
		int    nbytes;
		int    bad_idx;
		int    alt_idx;
		int    extra;
		bit    fb;
		item_t it;
		fb = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 70) begin
			len_field = $urandom_range(32, 12);
		end else if (pick < 80) begin
			len_field = $urandom_range(128, 33);
		end else if (pick < 85) begin
			// lengths just past the format b split get extra weight
			len_field = ($urandom_range(2) == 0) ? $urandom_range(130, 129)
			                                     : $urandom_range(256, 129);
		end else if (pick < 97) begin
			len_field = $urandom_range(11, 1);
		end else if (pick < 99) begin
			len_field = 0;
		end else begin
			len_field = $urandom_range(LEN_FIELD_MAX, 257);
		end
		len_true = (len_field == 0) ? 1 : ((len_field > MAX_FRAME) ? MAX_FRAME : len_field);
		nbytes = len_true;
		bad_idx = ($urandom_range(9) == 0) ? int'($urandom_range(len_true - 1)) : -1;
		alt_idx = -1;
		pick = $urandom_range(19);
		if (pick == 0 && len_true > 1) begin
			// frame cut short, the next frame_start restarts checking
			nbytes = $urandom_range(len_true - 1, 1);
		end else if (pick == 1) begin
			alt_idx = $urandom_range(len_true - 1);
		end
		for (int i = 0; i < nbytes; i++) begin
			it.frame_start = (i == 0);
			it.format_b = fb;
			it.frame_size = (i == alt_idx) ? 9'($urandom_range(LEN_FIELD_MAX, 1))
			                               : 9'(len_field);
			if (i > 0 && blk_phase == PH_CRC_HI) begin
				it.data_byte = ~run_crc[15:8];
			end else if (i > 0 && blk_phase == PH_CRC_LO) begin
				it.data_byte = ~run_crc[7:0];
			end else begin
				it.data_byte = 8'($urandom);
			end
			if (i == bad_idx) begin
				it.data_byte ^= 8'(1 << $urandom_range(7));
			end
			push_beat(it, 1'b0, '0);
			beats_sent++;
		end
		// stray bytes with no frame_start after the frame
		if ($urandom_range(7) == 0) begin
			extra = $urandom_range(3, 1);
			for (int j = 0; j < extra; j++) begin
				it.frame_start = 1'b0;
				it.format_b = 1'($urandom_range(1));
				it.frame_size = 9'($urandom_range(LEN_FIELD_MAX));
				it.data_byte = 8'($urandom);
				push_beat(it, 1'b0, '0);
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		int start_beats;
		int start_verdicts;
		send_idle = idle_pct;
		recv_stall = stall_pct;
		start_beats = beats_sent;
		start_verdicts = verdicts_due;
		while (beats_sent - start_beats < PHASE_BEATS
				|| verdicts_due - start_verdicts < PHASE_VERDICTS) begin
			run_frame();
		end
		drain();
	endtask

	always @(posedge clk) begin
		result_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
		if (result_valid && !result_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: verdict with none expected, actual crc_ok %b too_short %b",
					$time, result.crc_ok, result.too_short);
				errors++;
			end else begin
				want_v = verdict_q.pop_front();
				if (result.crc_ok !== want_v.crc_ok) begin
					$display("%0t: crc_ok expected %b actual %b", $time, want_v.crc_ok,
						result.crc_ok);
					errors++;
				end
				if (result.too_short !== want_v.too_short) begin
					$display("%0t: too_short expected %b actual %b", $time, want_v.too_short,
						result.too_short);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("wmbus_frame_block_crc_check_tb: done, errors");
			$finish;
		end
	end

	initial begin
		// one byte frame right after reset, frame_start low
		add_row(1'b0, 1'b0, 1, 8'h00, 1'b1, 1'b0, 1'b1);
		// zero length acts as one
		add_row(1'b1, 1'b1, 0, 8'hFF, 1'b1, 1'b0, 1'b1);
		// format b, 10 zero bytes: crc is zero, inverted ffff
		for (int i = 0; i < 10; i++) begin
			add_row(i == 0, 1'b1, 12, 8'h00, 1'b0, 1'b0, 1'b0);
		end
		add_row(1'b0, 1'b1, 12, 8'hFF, 1'b0, 1'b0, 1'b0);
		add_row(1'b0, 1'b1, 12, 8'hFF, 1'b1, 1'b1, 1'b0);
		// format a, same data but crc bytes zero
		for (int i = 0; i < 11; i++) begin
			add_row(i == 0, 1'b0, 12, 8'h00, 1'b0, 1'b0, 1'b0);
		end
		add_row(1'b0, 1'b0, 12, 8'h00, 1'b1, 1'b0, 1'b0);
		// byte after the verdict, length above the maximum
		add_row(1'b0, 1'b1, LEN_FIELD_MAX, 8'h5A, 1'b0, 1'b0, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[n]) begin
			push_beat(dir_rows[n].it, dir_rows[n].known, dir_rows[n].verdict);
		end
		drain();
		run_phase(0, 0);
		run_phase(63, 0);
		run_phase(0, 63);
		run_phase(12, 12);
		if (errors == 0) begin
			$display("wmbus_frame_block_crc_check_tb: done, clean");
		end else begin
			$display("wmbus_frame_block_crc_check_tb: done, errors");
		end
		$finish;
	end

endmodule
